### rtl/dae_pkg.sv
// ----------------------------------------------------------------------------
// dae_pkg
// Shared constants, codes and types of the dynamic array engine.
// ----------------------------------------------------------------------------
package dae_pkg;

  // Store geometry.
  localparam int unsigned DEPTH      = 1024;
  localparam int unsigned DATA_WIDTH = 32;
  localparam int unsigned ADDR_W     = $clog2(DEPTH);
  localparam int unsigned CNT_W      = $clog2(DEPTH + 1);

  // Fixed field widths of the channels.
  localparam int unsigned REQ_W    = 3;
  localparam int unsigned IDX_W    = 11;
  localparam int unsigned WORD_W   = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned POS_W    = 10;
  localparam int unsigned SIZE_W   = 11;

  // Width used to compare an index field against the element count.
  localparam int unsigned CMP_W = (CNT_W > IDX_W) ? CNT_W + 1 : IDX_W + 1;

  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);

  typedef enum logic [REQ_W-1:0] {
    REQ_APPEND = 3'd0,
    REQ_INSERT = 3'd1,
    REQ_SET    = 3'd2,
    REQ_DELETE = 3'd3,
    REQ_GET    = 3'd4,
    REQ_SEARCH = 3'd5
  } dae_req_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_BAD_INDEX = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } dae_status_e;

  // One result item as it leaves the sequencer.
  typedef struct packed {
    dae_status_e         status;
    logic [WORD_W-1:0]   value;
    logic [POS_W-1:0]    position;
    logic [SIZE_W-1:0]   size;
    logic [SIZE_W-1:0]   capacity;
    logic                empty_res;
    logic                full_res;
  } dae_rsp_t;

  // Access request from the sequencer to the element store.
  typedef struct packed {
    logic                  we;
    logic [ADDR_W-1:0]     waddr;
    logic [DATA_WIDTH-1:0] wdata;
    logic                  re;
    logic [ADDR_W-1:0]     raddr;
  } dae_mem_t;

  // Loads a capacity value, forcing it into the range 1 to DEPTH.
  function automatic logic [CNT_W-1:0] clamp_capacity(input logic [SIZE_W-1:0] v);
    logic [CNT_W-1:0] c;
    if (v == '0) begin
      c = CNT_W'(1);
    end else if (32'(v) > DEPTH) begin
      c = DEPTH_C;
    end else begin
      c = CNT_W'(v);
    end
    return c;
  endfunction

endpackage

### rtl/dae_if.sv
// ----------------------------------------------------------------------------
// dae_if
// Valid/ready channels of the dynamic array engine: request, response and
// configuration write.
// ----------------------------------------------------------------------------
interface dae_req_if import dae_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [REQ_W-1:0]  req_type;
  logic [IDX_W-1:0]  index;
  logic [WORD_W-1:0] data;

  modport source (output valid, output req_type, output index, output data, input ready);
  modport sink   (input valid, input req_type, input index, input data, output ready);
endinterface

interface dae_rsp_if import dae_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [WORD_W-1:0]   value;
  logic [POS_W-1:0]    position;
  logic [SIZE_W-1:0]   size;
  logic [SIZE_W-1:0]   capacity;
  logic                empty_res;
  logic                full_res;

  modport source (output valid, output status, output value, output position,
                  output size, output capacity, output empty_res, output full_res,
                  input ready);
  modport sink   (input valid, input status, input value, input position,
                  input size, input capacity, input empty_res, input full_res,
                  output ready);
endinterface

interface dae_cfg_if import dae_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [SIZE_W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### rtl/dae_ram.sv
// ----------------------------------------------------------------------------
// dae_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data.
// ----------------------------------------------------------------------------
module dae_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/dae_seq.sv
// ----------------------------------------------------------------------------
// dae_seq
// Request sequencer: keeps size and capacity, decides each request and walks
// the element store for insert, delete and search.
// ----------------------------------------------------------------------------
module dae_seq import dae_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Request item.
  input  logic                  req_valid_i,
  output logic                  req_ready_o,
  input  logic [REQ_W-1:0]      req_type_i,
  input  logic [IDX_W-1:0]      req_index_i,
  input  logic [WORD_W-1:0]     req_data_i,
  // Configuration write.
  input  logic                  cfg_valid_i,
  input  logic [SIZE_W-1:0]     cfg_data_i,
  // Result item towards the output register.
  output logic                  res_valid_o,
  input  logic                  res_ready_i,
  output dae_rsp_t              res_o,
  // Element store.
  output dae_mem_t              mem_o,
  input  logic [DATA_WIDTH-1:0] rdata_i
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_GET,
    S_INS,
    S_INS_LAST,
    S_INS_WR,
    S_DEL,
    S_DEL_LAST,
    S_SRCH,
    S_SRCH_LAST,
    S_RESP
  } state_e;

  state_e                state_q, state_d;
  logic [CNT_W-1:0]      count_q, count_d;
  logic [CNT_W-1:0]      cap_q, cap_d;
  logic [ADDR_W-1:0]     ptr_q, ptr_d;
  logic [ADDR_W-1:0]     lim_q, lim_d;
  logic [ADDR_W-1:0]     wa_q, wa_d;
  logic                  pend_q, pend_d;
  logic [DATA_WIDTH-1:0] word_q, word_d;
  dae_status_e           status_q, status_d;
  logic [WORD_W-1:0]     value_q, value_d;
  logic [POS_W-1:0]      pos_q, pos_d;

  logic [CMP_W-1:0]      idx_x, cnt_x;
  logic [CNT_W:0]        cap_dbl;
  logic [CNT_W-1:0]      cap_grow, cap_room, cnt_dec;
  logic                  room;

  // Capacity after an attempt to make room for one more element.
  always_comb begin
    idx_x   = CMP_W'(req_index_i);
    cnt_x   = CMP_W'(count_q);
    cap_dbl = {cap_q, 1'b0};
    if (cap_q >= DEPTH_C) begin
      cap_grow = cap_q;
    end else if (cap_dbl > (CNT_W + 1)'(DEPTH)) begin
      cap_grow = DEPTH_C;
    end else begin
      cap_grow = cap_dbl[CNT_W-1:0];
    end
    cap_room = (count_q < cap_q) ? cap_q : cap_grow;
    room     = count_q < cap_room;
    cnt_dec  = count_q - CNT_W'(1);
  end

  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    cap_d    = cap_q;
    ptr_d    = ptr_q;
    lim_d    = lim_q;
    wa_d     = wa_q;
    pend_d   = pend_q;
    word_d   = word_q;
    status_d = status_q;
    value_d  = value_q;
    pos_d    = pos_q;
    mem_o    = '0;
    res_valid_o = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (req_valid_i) begin
          pend_d   = 1'b0;
          word_d   = DATA_WIDTH'(req_data_i);
          value_d  = '0;
          pos_d    = '0;
          status_d = ST_OK;
          state_d  = S_RESP;
          case (dae_req_e'(req_type_i))
            REQ_APPEND: begin
              cap_d = cap_room;
              if (room) begin
                mem_o.we    = 1'b1;
                mem_o.waddr = ADDR_W'(count_q);
                mem_o.wdata = DATA_WIDTH'(req_data_i);
                count_d     = count_q + CNT_W'(1);
              end else begin
                status_d = ST_FULL;
              end
            end
            REQ_INSERT: begin
              if (idx_x > cnt_x) begin
                status_d = ST_BAD_INDEX;
              end else begin
                cap_d = cap_room;
                if (room) begin
                  count_d = count_q + CNT_W'(1);
                  lim_d   = ADDR_W'(req_index_i);
                  if (idx_x < cnt_x) begin
                    ptr_d   = ADDR_W'(cnt_dec);
                    state_d = S_INS;
                  end else begin
                    state_d = S_INS_WR;
                  end
                end else begin
                  status_d = ST_FULL;
                end
              end
            end
            REQ_SET: begin
              if (idx_x >= cnt_x) begin
                status_d = ST_BAD_INDEX;
              end else begin
                mem_o.we    = 1'b1;
                mem_o.waddr = ADDR_W'(req_index_i);
                mem_o.wdata = DATA_WIDTH'(req_data_i);
              end
            end
            REQ_DELETE: begin
              if (idx_x >= cnt_x) begin
                status_d = ST_BAD_INDEX;
              end else begin
                count_d = cnt_dec;
                if (cap_q > CNT_W'(1) && cnt_dec <= (cap_q >> 1)) begin
                  cap_d = cap_q >> 1;
                end
                if (idx_x + CMP_W'(1) < cnt_x) begin
                  ptr_d   = ADDR_W'(req_index_i) + ADDR_W'(1);
                  lim_d   = ADDR_W'(cnt_dec);
                  state_d = S_DEL;
                end
              end
            end
            REQ_GET: begin
              if (idx_x >= cnt_x) begin
                status_d = ST_BAD_INDEX;
              end else begin
                mem_o.re    = 1'b1;
                mem_o.raddr = ADDR_W'(req_index_i);
                state_d     = S_GET;
              end
            end
            REQ_SEARCH: begin
              status_d = ST_NOT_FOUND;
              if (count_q != '0) begin
                ptr_d   = '0;
                lim_d   = ADDR_W'(cnt_dec);
                state_d = S_SRCH;
              end
            end
            default: begin
            end
          endcase
        end
      end

      S_GET: begin
        value_d = WORD_W'(rdata_i);
        state_d = S_RESP;
      end

      // Walk downwards: read entry ptr, write the previous read one place up.
      S_INS: begin
        mem_o.re    = 1'b1;
        mem_o.raddr = ptr_q;
        mem_o.we    = pend_q;
        mem_o.waddr = wa_q;
        mem_o.wdata = rdata_i;
        pend_d      = 1'b1;
        wa_d        = ptr_q + ADDR_W'(1);
        if (ptr_q == lim_q) begin
          state_d = S_INS_LAST;
        end else begin
          ptr_d = ptr_q - ADDR_W'(1);
        end
      end

      S_INS_LAST: begin
        mem_o.we    = 1'b1;
        mem_o.waddr = wa_q;
        mem_o.wdata = rdata_i;
        pend_d      = 1'b0;
        state_d     = S_INS_WR;
      end

      S_INS_WR: begin
        mem_o.we    = 1'b1;
        mem_o.waddr = lim_q;
        mem_o.wdata = word_q;
        state_d     = S_RESP;
      end

      // Walk upwards: read entry ptr, write the previous read one place down.
      S_DEL: begin
        mem_o.re    = 1'b1;
        mem_o.raddr = ptr_q;
        mem_o.we    = pend_q;
        mem_o.waddr = wa_q;
        mem_o.wdata = rdata_i;
        pend_d      = 1'b1;
        wa_d        = ptr_q - ADDR_W'(1);
        if (ptr_q == lim_q) begin
          state_d = S_DEL_LAST;
        end else begin
          ptr_d = ptr_q + ADDR_W'(1);
        end
      end

      S_DEL_LAST: begin
        mem_o.we    = 1'b1;
        mem_o.waddr = wa_q;
        mem_o.wdata = rdata_i;
        pend_d      = 1'b0;
        state_d     = S_RESP;
      end

      // Reads run one entry ahead of the compare.
      S_SRCH: begin
        if (pend_q && rdata_i == word_q) begin
          status_d = ST_OK;
          pos_d    = POS_W'(wa_q);
          state_d  = S_RESP;
        end else begin
          mem_o.re    = 1'b1;
          mem_o.raddr = ptr_q;
          pend_d      = 1'b1;
          wa_d        = ptr_q;
          if (ptr_q == lim_q) begin
            state_d = S_SRCH_LAST;
          end else begin
            ptr_d = ptr_q + ADDR_W'(1);
          end
        end
      end

      S_SRCH_LAST: begin
        if (rdata_i == word_q) begin
          status_d = ST_OK;
          pos_d    = POS_W'(wa_q);
        end
        state_d = S_RESP;
      end

      S_RESP: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    // A configuration write restarts the list; the user must send it only while idle, the block does not enforce this.
    if (cfg_valid_i) begin
      count_d = '0;
      cap_d   = clamp_capacity(cfg_data_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      count_q  <= '0;
      cap_q    <= clamp_capacity(SIZE_W'(4));
      ptr_q    <= '0;
      lim_q    <= '0;
      wa_q     <= '0;
      pend_q   <= 1'b0;
      word_q   <= '0;
      status_q <= ST_OK;
      value_q  <= '0;
      pos_q    <= '0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      cap_q    <= cap_d;
      ptr_q    <= ptr_d;
      lim_q    <= lim_d;
      wa_q     <= wa_d;
      pend_q   <= pend_d;
      word_q   <= word_d;
      status_q <= status_d;
      value_q  <= value_d;
      pos_q    <= pos_d;
    end
  end

  assign req_ready_o = (state_q == S_IDLE);

  always_comb begin
    res_o.status    = status_q;
    res_o.value     = value_q;
    res_o.position  = pos_q;
    res_o.size      = SIZE_W'(count_q);
    res_o.capacity  = SIZE_W'(cap_q);
    res_o.empty_res = (count_q == '0);
    res_o.full_res  = (count_q == cap_q);
  end

endmodule

### rtl/dynamic_array_engine.sv
// ----------------------------------------------------------------------------
// dynamic_array_engine
// Ordered list of words with append, insert, set, delete, get and search,
// and a logical capacity that doubles when full and halves when sparse.
// ----------------------------------------------------------------------------
// The engine takes one request item at a time and returns exactly one result
// item for it. All elements live in a single RAM with one write port and one
// read port and a registered read; insert, delete and search walk that RAM
// one entry per cycle, with reads running one entry ahead of the write or
// compare. The walk of insert and delete grows with the number of entries
// moved, and that of search with the position of the first match, or with
// the size when there is no match. A new request is accepted as soon as the
// previous result sits in the output register, even if the sink has not
// taken it yet.
// The configuration channel is always ready; a write clears the list and
// loads the capacity (0 is taken as 1, values above DEPTH as DEPTH). The
// store has no reset: entries are only read below the current size, and
// those have all been written.
// ----------------------------------------------------------------------------
module dynamic_array_engine import dae_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  dae_req_if.sink   req_i,
  dae_rsp_if.source rsp_o,
  dae_cfg_if.sink   cfg_i
);

  dae_rsp_t              res;
  logic                  res_valid;
  logic                  slot_free;
  dae_mem_t              mem;
  logic [DATA_WIDTH-1:0] rdata;

  // Output register: one finished result waits here for the sink.
  logic     rsp_valid_q;
  dae_rsp_t rsp_q;

  assign slot_free = !rsp_valid_q || rsp_o.ready;

  dae_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .req_type_i  (req_i.req_type),
    .req_index_i (req_i.index),
    .req_data_i  (req_i.data),
    .cfg_valid_i (cfg_i.valid),
    .cfg_data_i  (cfg_i.data),
    .res_valid_o (res_valid),
    .res_ready_i (slot_free),
    .res_o       (res),
    .mem_o       (mem),
    .rdata_i     (rdata)
  );

  dae_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem.we),
    .waddr_i (mem.waddr),
    .wdata_i (mem.wdata),
    .re_i    (mem.re),
    .raddr_i (mem.raddr),
    .rdata_o (rdata)
  );

  // The result register loads whenever the sequencer offers an item and the
  // slot is free; it empties when the sink takes the item with nothing new.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
      rsp_q       <= '0;
    end else begin
      if (res_valid && slot_free) begin
        rsp_valid_q <= 1'b1;
        rsp_q       <= res;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  assign cfg_i.ready     = 1'b1;
  assign rsp_o.valid     = rsp_valid_q;
  assign rsp_o.status    = rsp_q.status;
  assign rsp_o.value     = rsp_q.value;
  assign rsp_o.position  = rsp_q.position;
  assign rsp_o.size      = rsp_q.size;
  assign rsp_o.capacity  = rsp_q.capacity;
  assign rsp_o.empty_res = rsp_q.empty_res;
  assign rsp_o.full_res  = rsp_q.full_res;

endmodule

### rtl/dae_checker.sv
// ----------------------------------------------------------------------------
// dae_checker
// Port-level checks of the dynamic array engine, bound to the top level.
// ----------------------------------------------------------------------------
module dae_checker import dae_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                req_valid,
  input logic                req_ready,
  input logic                rsp_valid,
  input logic                rsp_ready,
  input logic [STATUS_W-1:0] rsp_status,
  input logic [SIZE_W-1:0]   rsp_size,
  input logic [SIZE_W-1:0]   rsp_capacity,
  input logic                rsp_empty,
  input logic                rsp_full
);

  default disable iff (!rst_ni);

  // Requests are taken one at a time: after an accept the port closes.
  assert property (@(posedge clk_i) req_valid && req_ready |=> !req_ready)
    else $error("request port stayed open after an accept");

  // The flags agree with the reported size and capacity.
  assert property (@(posedge clk_i) rsp_valid |->
      (rsp_empty == (rsp_size == '0)) && (rsp_full == (rsp_size == rsp_capacity)))
    else $error("empty or full flag disagrees with size and capacity");

  // Size never exceeds the capacity, which stays between 1 and DEPTH.
  assert property (@(posedge clk_i) rsp_valid |->
      rsp_size <= rsp_capacity && rsp_capacity != '0 && 32'(rsp_capacity) <= DEPTH)
    else $error("size or capacity out of range");

  // A stalled result holds its status, size and capacity.
  assert property (@(posedge clk_i) rsp_valid && !rsp_ready |=>
      rsp_valid && $stable(rsp_status) && $stable(rsp_size) && $stable(rsp_capacity))
    else $error("stalled result changed");

endmodule

bind dynamic_array_engine dae_checker u_dae_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .req_valid    (req_i.valid),
  .req_ready    (req_i.ready),
  .rsp_valid    (rsp_o.valid),
  .rsp_ready    (rsp_o.ready),
  .rsp_status   (rsp_o.status),
  .rsp_size     (rsp_o.size),
  .rsp_capacity (rsp_o.capacity),
  .rsp_empty    (rsp_o.empty_res),
  .rsp_full     (rsp_o.full_res)
);
